[hdl/lie_pkg.sv]
// Package for the lowest-ID leader election block.
// Holds the mode encoding, register indexes and the payload, state and
// register-file structs. No dependencies.
package lie_pkg;

   // Node modes
   typedef enum logic [2:0] {
      MODE_GROUND    = 3'd0,
      MODE_CALIB     = 3'd1,
      MODE_LISTEN    = 3'd2,
      MODE_CANDIDATE = 3'd3,
      MODE_LEADER    = 3'd4,
      MODE_FOLLOWER  = 3'd5,
      MODE_HOLDOVER  = 3'd6
   } mode_type;

   // Input commands
   localparam logic CMD_TICK     = 1'b0;
   localparam logic CMD_ANNOUNCE = 1'b1;

   // Consecutive heartbeat misses that end followership
   localparam logic [1:0] MISS_LIMIT = 2'd3;

   // Register file
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ID          = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUND_TIME     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LISTEN_TIME     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEARTBEAT_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOVER_TIME   = 3'd4;

   localparam logic [39:0] GROUND_TIME_RST     = 40'd1000000000;
   localparam logic [28:0] LISTEN_TIME_RST     = 29'd250000000;
   localparam logic [39:0] HEARTBEAT_LIMIT_RST = 40'd1000000000;
   localparam logic [39:0] HOLDOVER_TIME_RST   = 40'd10000000000;

   typedef struct packed {
      logic [31:0] own_id;
      logic [39:0] ground_time;
      logic [28:0] listen_time;
      logic [39:0] heartbeat_limit;
      logic [39:0] holdover_time;
   } csr_type;

   typedef struct packed {
      logic        cmd;
      logic [62:0] now_time;
      logic [31:0] sender_node;
      logic [31:0] sender_epoch;
   } req_type;

   typedef struct packed {
      logic [2:0]  node_mode;
      logic [31:0] current_leader;
      logic [31:0] current_epoch;
   } rsp_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] leader;
      logic [31:0] epoch;
      logic [62:0] entry_time;
      logic [62:0] heard_time;
      logic [1:0]  miss_count;
   } state_type;

endpackage

[hdl/lie_csr.sv]
// Configuration register file for the leader election block.
// Plain write port, no read-back. Depends on lie_pkg.
module lie_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [lie_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lie_pkg::CSR_DATA_W-1:0]    csr_data,
   output lie_pkg::csr_type                  csr_regs
);

   lie_pkg::csr_type regs_ff;
   lie_pkg::csr_type regs_in;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      regs_in = regs_ff;
      if (csr_write) begin
         case (csr_index)
            lie_pkg::CSR_OWN_ID:          regs_in.own_id          = csr_data[31:0];
            lie_pkg::CSR_GROUND_TIME:     regs_in.ground_time     = csr_data[39:0];
            lie_pkg::CSR_LISTEN_TIME:     regs_in.listen_time     = csr_data[28:0];
            lie_pkg::CSR_HEARTBEAT_LIMIT: regs_in.heartbeat_limit = csr_data[39:0];
            lie_pkg::CSR_HOLDOVER_TIME:   regs_in.holdover_time   = csr_data[39:0];
            default:                      regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.own_id          <= 32'd0;
         regs_ff.ground_time     <= lie_pkg::GROUND_TIME_RST;
         regs_ff.listen_time     <= lie_pkg::LISTEN_TIME_RST;
         regs_ff.heartbeat_limit <= lie_pkg::HEARTBEAT_LIMIT_RST;
         regs_ff.holdover_time   <= lie_pkg::HOLDOVER_TIME_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_regs = regs_ff;

endmodule

[hdl/lie_step.sv]
// Next-state logic of the election state machine for one transfer.
// Purely combinational: current state, registers and item in, next state out.
// Depends on lie_pkg.
module lie_step (
   input  lie_pkg::state_type cur,
   input  lie_pkg::csr_type   regs,
   input  lie_pkg::req_type   req,
   output lie_pkg::state_type nxt
);

   logic [62:0] limit;
   logic [62:0] since_entry;
   logic [62:0] since_heard;
   logic        elapsed_hit;
   logic        hb_missed;
   logic [1:0]  miss_inc;
   logic        ann_listen;
   logic        ann_valid;
   logic        ann_lower;
   lie_pkg::mode_type mode_nxt;

   // Threshold for the mode's dwell timer
   always_comb begin
      case (cur.mode)
         lie_pkg::MODE_GROUND:   limit = {23'd0, regs.ground_time};
         lie_pkg::MODE_LISTEN:   limit = {34'd0, regs.listen_time};
         lie_pkg::MODE_HOLDOVER: limit = {23'd0, regs.holdover_time};
         default:                limit = '0;
      endcase
   end

   // Elapsed-time checks; time going backwards never reaches a threshold
   assign since_entry = req.now_time - cur.entry_time;
   assign since_heard = req.now_time - cur.heard_time;
   assign elapsed_hit = (req.now_time >= cur.entry_time) && (since_entry >= limit);
   assign hb_missed   = (req.now_time >= cur.heard_time) &&
                        (since_heard > {23'd0, regs.heartbeat_limit});
   assign miss_inc    = (cur.miss_count == lie_pkg::MISS_LIMIT) ?
                        lie_pkg::MISS_LIMIT : cur.miss_count + 2'd1;

   // Announce qualification: not while grounded or calibrating, not stale
   assign ann_listen = (cur.mode != lie_pkg::MODE_GROUND) &&
                       (cur.mode != lie_pkg::MODE_CALIB);
   assign ann_valid  = ann_listen && (req.sender_epoch >= cur.epoch);
   assign ann_lower  = ann_valid && (req.sender_node < regs.own_id);

   // Next mode
   always_comb begin
      mode_nxt = cur.mode;
      if (req.cmd == lie_pkg::CMD_TICK) begin
         case (cur.mode)
            lie_pkg::MODE_GROUND:
               if (elapsed_hit) mode_nxt = lie_pkg::MODE_CALIB;
            lie_pkg::MODE_CALIB:
               mode_nxt = lie_pkg::MODE_LISTEN;
            lie_pkg::MODE_LISTEN:
               if (cur.heard_time == '0 && elapsed_hit) mode_nxt = lie_pkg::MODE_CANDIDATE;
            lie_pkg::MODE_CANDIDATE:
               mode_nxt = lie_pkg::MODE_LEADER;
            lie_pkg::MODE_FOLLOWER:
               if (hb_missed && miss_inc == lie_pkg::MISS_LIMIT)
                  mode_nxt = lie_pkg::MODE_HOLDOVER;
            lie_pkg::MODE_HOLDOVER:
               if (elapsed_hit) mode_nxt = lie_pkg::MODE_CANDIDATE;
            default:
               mode_nxt = cur.mode;
         endcase
      end else if (ann_lower) begin
         mode_nxt = lie_pkg::MODE_FOLLOWER;
      end
   end

   // Leader, term, timestamps and miss counter
   always_comb begin
      nxt      = cur;
      nxt.mode = mode_nxt;
      // every mode change restarts the dwell timer
      if (mode_nxt != cur.mode) nxt.entry_time = req.now_time;
      if (req.cmd == lie_pkg::CMD_TICK) begin
         case (cur.mode)
            lie_pkg::MODE_LISTEN,
            lie_pkg::MODE_HOLDOVER:
               if (mode_nxt == lie_pkg::MODE_CANDIDATE) nxt.epoch = cur.epoch + 32'd1;
            lie_pkg::MODE_CANDIDATE:
               nxt.leader = regs.own_id;
            lie_pkg::MODE_FOLLOWER: begin
               if (hb_missed) begin
                  nxt.miss_count = miss_inc;
                  if (miss_inc == lie_pkg::MISS_LIMIT) nxt.leader = 32'd0;
               end else begin
                  nxt.miss_count = 2'd0;
               end
            end
            default:
               nxt.leader = cur.leader;
         endcase
      end else begin
         if (ann_valid) nxt.epoch = req.sender_epoch;
         if (ann_lower) begin
            nxt.leader     = req.sender_node;
            nxt.miss_count = 2'd0;
            nxt.heard_time = req.now_time;
         end
      end
   end

endmodule

[hdl/lowest_id_leader_election.sv]
// Lowest-ID leader election: an input transfer goes into the input register, then the
// state update writes the result register; a stalled result can hold it between the two.
// Throughput is one item per cycle while the result is not stalled; the next-state logic
// is combinational from the state registers, so consecutive items chain with no bubble.
// A stalled result holds the input register, which then stalls the input.
// Reset (synchronous, active high) puts the node in ground with leader, term,
// timestamps and miss count at zero and the registers at their defaults.
module lowest_id_leader_election (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lie_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lie_pkg::rsp_type                 rsp_data,
   input  logic                             csr_write,
   input  logic [lie_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lie_pkg::CSR_DATA_W-1:0]   csr_data
);

   lie_pkg::csr_type   csr_regs;
   lie_pkg::req_type   req_ff;
   logic               s1_valid_ff, s1_valid_in;
   lie_pkg::rsp_type   rsp_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   lie_pkg::state_type state_ff, state_in;
   logic               out_free;
   logic               s1_fire;
   logic               req_accept;

   lie_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_regs  (csr_regs)
   );

   lie_step u_step (
      .cur  (state_ff),
      .regs (csr_regs),
      .req  (req_ff),
      .nxt  (state_in)
   );

   // Handshake control
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_fire ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         state_ff.mode       <= lie_pkg::MODE_GROUND;
         state_ff.leader     <= 32'd0;
         state_ff.epoch      <= 32'd0;
         state_ff.entry_time <= 63'd0;
         state_ff.heard_time <= 63'd0;
         state_ff.miss_count <= 2'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) req_ff <= req_data;
      if (s1_fire) begin
         rsp_ff.node_mode      <= state_in.mode;
         rsp_ff.current_leader <= state_in.leader;
         rsp_ff.current_epoch  <= state_in.epoch;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // State only moves when an item is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(state_ff))
      else $error("state changed without a processed item");

   // Term never goes backwards except by wrapping increment
   a_epoch_mono: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> (state_ff.epoch >= $past(state_ff.epoch)) ||
                  (state_ff.epoch == $past(state_ff.epoch) + 32'd1))
      else $error("term went backwards");

   // A follower never sits at the miss limit
   a_follow_miss: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == lie_pkg::MODE_FOLLOWER |-> state_ff.miss_count != lie_pkg::MISS_LIMIT)
      else $error("follower at miss limit");

   // Holdover has no known leader
   a_hold_leader: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode == lie_pkg::MODE_HOLDOVER |-> state_ff.leader == 32'd0)
      else $error("leader set in holdover");

   // A new result appears only after a processed item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire))
      else $error("result without processed item");

endmodule
